FILE: hdl/chained_hash_key_value_table_defines.svh
// ----------------------------------------------------------------------------
// Chained hash key-value table assertion macros
// Shared helpers for the concurrent checks of the table.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_KEY_VALUE_TABLE_DEFINES_SVH
`define CHAINED_HASH_KEY_VALUE_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHKV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHKV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/chkv_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash key-value table package
// Request kinds, default sizes and state types shared by the table modules.
// ----------------------------------------------------------------------------
package chkv_pkg;

	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int BUCKETS_DEF    = 64;
	localparam int CAPACITY_DEF   = 256;

	localparam logic [2:0] KIND_INSERT     = 3'd0;
	localparam logic [2:0] KIND_INS_UPDATE = 3'd1;
	localparam logic [2:0] KIND_UPDATE     = 3'd2;
	localparam logic [2:0] KIND_REMOVE     = 3'd3;
	localparam logic [2:0] KIND_FIND       = 3'd4;
	localparam logic [2:0] KIND_CLEAR      = 3'd5;

	localparam logic [31:0] HASH_MULT = 32'h9E3779B1;

	typedef enum logic [2:0] {
		H_IDLE,
		H_MUL,
		H_MIX,
		H_RCP,
		H_REM,
		H_FIX
	} hash_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH,
		S_HEAD,
		S_HWAIT,
		S_READ,
		S_CMP,
		S_ACT,
		S_SCAN,
		S_ALLOC,
		S_LINK,
		S_DONE
	} state_t;

endpackage

FILE: hdl/chkv_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/chkv_hash.sv
// ----------------------------------------------------------------------------
// Bucket hash unit
// Multiplicative hash followed by a reciprocal-multiply remainder by the
// bucket count, or by a mask when the bucket count is a power of two.
// ----------------------------------------------------------------------------
module chkv_hash #(
	parameter int BUCKETS = chkv_pkg::BUCKETS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	input  logic [31:0]                                   key,
	output logic                                          done,
	output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);
	import chkv_pkg::*;

	localparam int  BBW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam bit  POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));

	hash_state_t   state_q, state_d;
	logic [31:0]   key_q;
	logic [31:0]   prod_q;
	logic [31:0]   mix_q;
	logic [31:0]   quo_q;
	logic [31:0]   rem_q;
	logic [63:0]   rcp_prod;
	logic          done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			H_IDLE: if (start) state_d = H_MUL;
			H_MUL:  state_d = H_MIX;
			H_MIX:  state_d = POW2 ? H_IDLE : H_RCP;
			H_RCP:  state_d = H_REM;
			H_REM:  state_d = H_FIX;
			H_FIX:  state_d = H_IDLE;
			default: state_d = H_IDLE;
		endcase
	end

	// The truncated reciprocal underestimates the quotient by at most one.
	assign rcp_prod = {32'd0, mix_q} * {32'd0, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == H_MIX) && POW2) || (state_q == H_FIX);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			H_IDLE: if (start) key_q <= key;
			H_MUL:  prod_q <= key_q * HASH_MULT;
			H_MIX:  mix_q <= prod_q ^ (prod_q >> 16);
			H_RCP:  quo_q <= rcp_prod[63:32];
			H_REM:  rem_q <= mix_q - quo_q * 32'(BUCKETS);
			H_FIX:  if (rem_q >= 32'(BUCKETS)) rem_q <= rem_q - 32'(BUCKETS);
			default: ;
		endcase
	end

	assign done   = done_q;
	assign bucket = POW2 ? BBW'(mix_q & 32'(BUCKETS - 1)) : rem_q[BBW-1:0];

endmodule

FILE: hdl/chained_hash_key_value_table.sv
// ----------------------------------------------------------------------------
// Chained hash key-value table
// Requests enter on the s_ stream, one result per request leaves on m_.
// A request is taken only while the sequencer is idle. Insert, update,
// remove and find hash the key in the hash unit, read the bucket head,
// then walk the chain one visited entry at a time through the entry RAMs.
// A new entry adds a free-slot scan of one 16-slot word per cycle,
// followed by allocation and linking. Clear and unused kinds finish at once.
// The result sits in an output register: the next request is taken while
// a result waits, but the sequencer holds its next result until the
// receiver takes the previous one. Reset empties the table at once through
// valid bits for buckets and pool slots; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "chained_hash_key_value_table_defines.svh"

module chained_hash_key_value_table #(
	parameter int KEY_BITS   = chkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = chkv_pkg::VALUE_BITS_DEF,
	parameter int BUCKETS    = chkv_pkg::BUCKETS_DEF,
	parameter int CAPACITY   = chkv_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // key [31:0], value [63:32]
	input  logic [2:0]  s_tuser,  // kind [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // value_out [31:0], entry_count [40:32], zero [47:41]
	output logic        m_tuser   // ok [0]
);
	import chkv_pkg::*;

	localparam int KSW   = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int VSW   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int BBW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW    = $clog2(CAPACITY + 1);
	localparam int WB    = 16;
	localparam int WORDS = (CAPACITY + WB - 1) / WB;
	localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SW    = $clog2(WORDS * WB);
	localparam int LW    = WIW + 4;
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);

	state_t            state_q, state_d;
	logic [2:0]        kind_q;
	logic [KSW-1:0]    key_q;
	logic [VSW-1:0]    val_q;
	logic [PW-1:0]     cur_q, prev_q, nexts_q, steps_q;
	logic [AW-1:0]     slot_q, f_q;
	logic [VSW-1:0]    old_q;
	logic              found_q;
	logic              ok_q;
	logic [VSW-1:0]    vo_q;
	logic [PW-1:0]     count_q;
	logic [WIW-1:0]    scan_w_q;
	logic [WORDS*WB-1:0] used_q;
	logic [BUCKETS-1:0]  head_valid_q;
	logic              out_ok_q;
	logic [VSW-1:0]    out_vo_q;
	logic [PW-1:0]     out_cnt_q;
	logic              out_valid_q;

	logic              accept, hash_start, hash_done;
	logic [BBW-1:0]    bucket;
	logic              walk_end, key_hit, is_ins, rem_found;
	logic [WB-1:0]     scan_word, scan_free;
	logic              scan_hit;
	logic [3:0]        scan_idx;
	logic [LW-1:0]     scan_slot;

	logic              key_we, val_we, next_we, head_we;
	logic [AW-1:0]     val_waddr, next_waddr, ent_raddr;
	logic [VSW-1:0]    val_wdata;
	logic [PW-1:0]     next_wdata, head_wdata;
	logic [KSW-1:0]    key_rd;
	logic [VSW-1:0]    val_rd;
	logic [PW-1:0]     next_rd, head_rd;

	assign accept     = s_tvalid && s_tready;
	assign s_tready   = (state_q == S_IDLE);
	assign hash_start = accept && (s_tuser <= KIND_FIND);
	assign walk_end   = (cur_q == NIL) || (steps_q == NIL);
	assign key_hit    = (key_rd == key_q);
	assign is_ins     = (kind_q == KIND_INSERT) || (kind_q == KIND_INS_UPDATE);
	assign rem_found  = (state_q == S_ACT) && found_q && (kind_q == KIND_REMOVE);

	chkv_hash #(.BUCKETS(BUCKETS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (32'(s_tdata[KSW-1:0])),
		.done   (hash_done),
		.bucket (bucket)
	);

	// Lowest free slot of the word under scan; padding past the pool never counts.
	always_comb begin
		logic [LW-1:0] cand;
		scan_word = used_q[int'(scan_w_q)*WB +: WB];
		scan_hit  = 1'b0;
		scan_idx  = '0;
		for (int i = 0; i < WB; i++) begin
			cand         = {scan_w_q, 4'(i)};
			scan_free[i] = !scan_word[i] && (int'(cand) < CAPACITY);
		end
		for (int i = WB - 1; i >= 0; i--) begin
			if (scan_free[i]) begin
				scan_hit = 1'b1;
				scan_idx = 4'(i);
			end
		end
		scan_slot = {scan_w_q, scan_idx};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) begin
				state_d = (s_tuser <= KIND_FIND) ? S_HASH : S_DONE;
			end
			S_HASH:  if (hash_done) state_d = S_HEAD;
			S_HEAD:  state_d = S_HWAIT;
			S_HWAIT: state_d = S_READ;
			S_READ:  state_d = walk_end ? S_ACT : S_CMP;
			S_CMP:   state_d = key_hit ? S_ACT : S_READ;
			S_ACT:   state_d = (!found_q && is_ins) ? S_SCAN : S_DONE;
			S_SCAN: begin
				if (scan_hit) state_d = S_ALLOC;
				else if (int'(scan_w_q) == WORDS - 1) state_d = S_DONE;
			end
			S_ALLOC: state_d = S_LINK;
			S_LINK:  state_d = S_DONE;
			S_DONE:  if (!out_valid_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		key_we     = (state_q == S_ALLOC);
		val_we     = 1'b0;
		val_waddr  = f_q;
		val_wdata  = val_q;
		next_we    = 1'b0;
		next_waddr = f_q;
		next_wdata = NIL;
		head_we    = 1'b0;
		head_wdata = PW'(f_q);
		ent_raddr  = AW'(cur_q);
		unique case (state_q)
			S_ACT: begin
				if (found_q && (kind_q == KIND_INS_UPDATE || kind_q == KIND_UPDATE)) begin
					val_we    = 1'b1;
					val_waddr = slot_q;
				end
				if (rem_found) begin
					// Unlink the entry from its predecessor or from the bucket head.
					next_we    = (prev_q != NIL);
					next_waddr = AW'(prev_q);
					next_wdata = nexts_q;
					head_we    = (prev_q == NIL);
					head_wdata = nexts_q;
				end
			end
			S_ALLOC: begin
				val_we  = 1'b1;
				next_we = 1'b1;
			end
			S_LINK: begin
				next_we    = (prev_q != NIL);
				next_waddr = AW'(prev_q);
				next_wdata = PW'(f_q);
				head_we    = (prev_q == NIL);
			end
			default: ;
		endcase
	end

	chkv_ram #(.WIDTH(KSW), .DEPTH(CAPACITY)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(f_q), .wdata(key_q), .raddr(ent_raddr), .rdata(key_rd)
	);

	chkv_ram #(.WIDTH(VSW), .DEPTH(CAPACITY)) u_val_ram (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.raddr(ent_raddr), .rdata(val_rd)
	);

	chkv_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(ent_raddr), .rdata(next_rd)
	);

	chkv_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(bucket), .wdata(head_wdata),
		.raddr(bucket), .rdata(head_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			used_q       <= '0;
			head_valid_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (s_tuser == KIND_CLEAR)) begin
				count_q      <= '0;
				used_q       <= '0;
				head_valid_q <= '0;
			end
			if (head_we) head_valid_q[bucket] <= 1'b1;
			if (rem_found) begin
				used_q[SW'(slot_q)] <= 1'b0;
				if (count_q != '0) count_q <= count_q - 1'b1;
			end
			if (state_q == S_ALLOC) begin
				used_q[SW'(f_q)] <= 1'b1;
				count_q          <= count_q + 1'b1;
			end
			if ((state_q == S_DONE) && (!out_valid_q || m_tready)) out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (accept) begin
				kind_q <= s_tuser;
				key_q  <= s_tdata[KSW-1:0];
				val_q  <= s_tdata[32 +: VSW];
				ok_q   <= (s_tuser == KIND_CLEAR);
				vo_q   <= '0;
			end
			S_HWAIT: begin
				cur_q   <= head_valid_q[bucket] ? head_rd : NIL;
				prev_q  <= NIL;
				steps_q <= '0;
				found_q <= 1'b0;
			end
			S_CMP: begin
				if (key_hit) begin
					found_q <= 1'b1;
					slot_q  <= AW'(cur_q);
					nexts_q <= next_rd;
					old_q   <= val_rd;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= next_rd;
					steps_q <= steps_q + 1'b1;
				end
			end
			S_ACT: begin
				scan_w_q <= '0;
				if (found_q && (kind_q != KIND_INSERT)) begin
					ok_q <= 1'b1;
					vo_q <= old_q;
				end
			end
			S_SCAN: begin
				if (scan_hit) f_q <= AW'(scan_slot);
				else scan_w_q <= scan_w_q + 1'b1;
			end
			S_ALLOC: ok_q <= 1'b1;
			S_DONE: if (!out_valid_q || m_tready) begin
				out_ok_q  <= ok_q;
				out_vo_q  <= vo_q;
				out_cnt_q <= count_q;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = {7'd0, 9'(out_cnt_q), 32'(out_vo_q)};

	`CHKV_ASSERT_NEXT(a_clear_empties, accept && (s_tuser == KIND_CLEAR), count_q == '0,
		"clear left entries in the table")
	`CHKV_ASSERT_NEXT(a_alloc_counts, state_q == S_ALLOC, count_q == $past(count_q) + 1'b1,
		"allocation did not raise the entry count")
	`CHKV_ASSERT_NOW(a_count_bound, state_q == S_ALLOC, count_q < NIL,
		"allocation with a full pool")
	`CHKV_ASSERT_NEXT(a_result_loaded, (state_q == S_DONE) && (!out_valid_q || m_tready),
		m_tvalid && (state_q == S_IDLE), "finished result was not presented")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash key-value table testbench
// Drives random and directed requests with random gaps and stalls. A local
// model of the table predicts every result, and the monitor compares them.
// ----------------------------------------------------------------------------
module tb;
	import chkv_pkg::*;

	localparam int NBKT = 64;
	localparam int NCAP = 256;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] key;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] value_out;
		logic [8:0]  entry_count;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;

	chained_hash_key_value_table dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Predicted table contents.
	logic [31:0] slot_key [NCAP];
	logic [31:0] slot_val [NCAP];
	logic [8:0]  slot_next [NCAP];
	logic        slot_used [NCAP];
	logic [8:0]  head [NBKT];
	logic [8:0]  live_entries;

	request_t pending_requests[$];
	answer_t  expected_answers[$];
	logic [31:0] key_pool[$];
	int errors = 0;
	int requests_sent = 0;
	int answers_seen = 0;
	int full_hits = 0;
	int idle_cycles = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	int hold_off = 0;
	bit stall_done = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [5:0] bucket_index(logic [31:0] k);
		logic [31:0] m;
		m = k * HASH_MULT;
		return 6'((m ^ (m >> 16)) % NBKT);
	endfunction

	function automatic void empty_table();
		for (int i = 0; i < NCAP; i++) begin
			slot_used[i] = 1'b0;
			slot_next[i] = 9'(NCAP);
		end
		for (int i = 0; i < NBKT; i++) head[i] = 9'(NCAP);
		live_entries = '0;
	endfunction

	function automatic answer_t apply_request(request_t r);
		answer_t a;
		logic [5:0] b;
		int cur, prv, hit, steps, f, t;
		a = '0;
		b = bucket_index(r.key);
		hit = NCAP;
		prv = NCAP;
		cur = head[b];
		steps = 0;
		if (r.kind <= KIND_FIND) begin
			while (cur < NCAP && steps < NCAP && hit == NCAP) begin
				if (slot_used[cur] && slot_key[cur] == r.key) hit = cur;
				else begin
					prv = cur;
					cur = slot_next[cur];
					steps++;
				end
			end
		end
		if (r.kind == KIND_INSERT || r.kind == KIND_INS_UPDATE || r.kind == KIND_UPDATE) begin
			if (hit < NCAP) begin
				if (r.kind != KIND_INSERT) begin
					a.value_out = slot_val[hit];
					slot_val[hit] = r.value;
					a.ok = 1'b1;
				end
			end else if (r.kind != KIND_UPDATE) begin
				f = 0;
				while (f < NCAP && slot_used[f]) f++;
				if (f < NCAP) begin
					slot_key[f] = r.key;
					slot_val[f] = r.value;
					slot_next[f] = 9'(NCAP);
					slot_used[f] = 1'b1;
					if (head[b] >= NCAP) head[b] = 9'(f);
					else begin
						t = head[b];
						while (slot_next[t] < NCAP) t = slot_next[t];
						slot_next[t] = 9'(f);
					end
					live_entries++;
					a.ok = 1'b1;
				end else full_hits++;
			end
		end else if (r.kind == KIND_REMOVE) begin
			if (hit < NCAP) begin
				a.value_out = slot_val[hit];
				if (prv < NCAP) slot_next[prv] = slot_next[hit];
				else head[b] = slot_next[hit];
				slot_used[hit] = 1'b0;
				slot_next[hit] = 9'(NCAP);
				live_entries--;
				a.ok = 1'b1;
			end
		end else if (r.kind == KIND_FIND) begin
			if (hit < NCAP) begin
				a.value_out = slot_val[hit];
				a.ok = 1'b1;
			end
		end else if (r.kind == KIND_CLEAR) begin
			empty_table();
			a.ok = 1'b1;
		end
		a.entry_count = live_entries;
		return a;
	endfunction

	function automatic void queue_request(logic [2:0] kind, logic [31:0] key, logic [31:0] value);
		request_t r;
		r.kind = kind;
		r.key = key;
		r.value = value;
		pending_requests.push_back(r);
		if (kind == KIND_INSERT || kind == KIND_INS_UPDATE) key_pool.push_back(key);
	endfunction

	function automatic logic [31:0] pick_key();
		if (key_pool.size() == 0 || $urandom_range(0, 4) == 0) return $urandom();
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			tx_wait <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_answers.push_back(apply_request({s_tuser, s_tdata[31:0], s_tdata[63:32]}));
				requests_sent <= requests_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_wait > 0) begin
					s_tvalid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (pending_requests.size() > 0) begin
					request_t r;
					r = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= r.kind;
					s_tdata <= {r.value, r.key};
					// Long runs without gaps come from the zero draws.
					tx_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
				end else s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor and receiver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
			hold_off <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				answer_t e;
				answers_seen <= answers_seen + 1;
				if (expected_answers.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					e = expected_answers.pop_front();
					if (m_tuser !== e.ok) begin
						$error("ok: expected %0d, got %0d", e.ok, m_tuser);
						errors++;
					end
					if (m_tdata[31:0] !== e.value_out) begin
						$error("value_out: expected %h, got %h", e.value_out, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[40:32] !== e.entry_count) begin
						$error("entry_count: expected %0d, got %0d", e.entry_count,
							m_tdata[40:32]);
						errors++;
					end
				end
			end
			if (!stall_done && requests_sent == 300) begin
				// One long hold-off lets the output register fill and stall the input.
				stall_done <= 1'b1;
				hold_off <= 400;
				m_tready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready || !m_tready && rx_wait == 0) begin
				if (m_tvalid && m_tready) begin
					rx_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
					m_tready <= 1'b0;
				end else m_tready <= 1'b1;
			end else if (!m_tready) rx_wait <= rx_wait - 1;
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] k;
		empty_table();
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: every kind, extreme keys and values, misses and hits.
		queue_request(KIND_FIND, 32'h0, 32'h0);
		queue_request(KIND_REMOVE, 32'hFFFFFFFF, 32'h0);
		queue_request(KIND_UPDATE, 32'h1, 32'h5);
		queue_request(KIND_INSERT, 32'h0, 32'hFFFFFFFF);
		queue_request(KIND_INSERT, 32'hFFFFFFFF, 32'h0);
		queue_request(KIND_INSERT, 32'h0, 32'h1234);
		queue_request(KIND_INS_UPDATE, 32'h0, 32'hA5A5A5A5);
		queue_request(KIND_INS_UPDATE, 32'h80000000, 32'h5A5A5A5A);
		queue_request(KIND_UPDATE, 32'hFFFFFFFF, 32'hFFFFFFFF);
		queue_request(KIND_FIND, 32'hFFFFFFFF, 32'h0);
		queue_request(KIND_REMOVE, 32'h0, 32'h0);
		queue_request(KIND_FIND, 32'h0, 32'h0);
		queue_request(3'd6, 32'h80000000, 32'h1);
		queue_request(3'd7, 32'h80000000, 32'h1);
		queue_request(KIND_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF);
		queue_request(KIND_FIND, 32'h80000000, 32'h0);

		// Random traffic, with two phases that fill the pool to overflow.
		for (int n = 0; n < 600; n++) begin
			if (n == 200 || n == 450) begin
				for (int i = 0; i < 270; i++) queue_request(KIND_INSERT, $urandom(), $urandom());
				queue_request(KIND_INS_UPDATE, $urandom(), $urandom());
				for (int i = 0; i < 30; i++) begin
					k = pick_key();
					queue_request(3'($urandom_range(0, 4)), k, $urandom());
				end
				queue_request(KIND_CLEAR, $urandom(), $urandom());
				key_pool.delete();
			end
			k = pick_key();
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4:  queue_request(KIND_INSERT, k, $urandom());
				5, 6, 7:        queue_request(KIND_INS_UPDATE, k, $urandom());
				8, 9:           queue_request(KIND_UPDATE, k, $urandom());
				10, 11, 12:     queue_request(KIND_REMOVE, k, $urandom());
				13, 14, 15, 16: queue_request(KIND_FIND, k, $urandom());
				17:             queue_request(3'($urandom_range(6, 7)), k, $urandom());
				default: begin
					if ($urandom_range(0, 9) == 0) begin
						queue_request(KIND_CLEAR, k, $urandom());
						key_pool.delete();
					end else queue_request(KIND_FIND, k, $urandom());
				end
			endcase
		end

		wait (pending_requests.size() == 0 && !s_tvalid);
		wait (expected_answers.size() == 0);
		repeat (100) @(posedge clk);
		$display("Covered %0d requests and %0d results over all kinds, with %0d full-pool refusals.",
			requests_sent, answers_seen, full_hits);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
